// ----- rtl/core/pablru_pkg.sv -----
// Shared types and constants for the per-address byte counter with LRU table.
package pablru_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;

    localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
    localparam logic [15:0] ETH_HDR_BYTES    = 16'd14;
    localparam logic [15:0] ETH_IP_HDR_BYTES = 16'd34;

    typedef struct packed {
        logic [15:0] frame_length;
        logic [15:0] ethertype;
        logic [15:0] ip_total_length;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
    } pkt_t;

    typedef struct packed {
        logic        counted;
        logic [63:0] src_total;
        logic [63:0] dst_total;
    } res_t;

    typedef struct packed {
        logic match_en;
        logic sel_en;
        logic write_en;
    } chain_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_SEL,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/core/pablru_cell.sv -----
// One table cell: holds an entry at a fixed recency position, shifts from its neighbor.
module pablru_cell
    import pablru_pkg::*;
#(
    parameter int IDX_W = 8,
    parameter int POS   = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  chain_cmd_t       cmd,
    input  logic [31:0]      lookup_key,
    input  logic             hit_any,
    input  logic [IDX_W-1:0] hit_idx,
    input  logic             din_valid,
    input  logic [31:0]      din_key,
    input  logic [63:0]      din_bytes,
    output logic             valid,
    output logic [31:0]      key,
    output logic [63:0]      bytes,
    output logic             match
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] key_reg;
    logic [31:0] key_next;
    logic [63:0] bytes_reg;
    logic [63:0] bytes_next;
    logic        match_reg;
    logic        match_next;
    logic        load;

    // cells at positions up to and including the hit position move down one place; on a miss all do
    assign load = cmd.write_en && (!hit_any || (IDX_W'(POS) <= hit_idx));

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        bytes_next = bytes_reg;
        match_next = match_reg;
        if (load)
        begin
            valid_next = din_valid;
            key_next   = din_key;
            bytes_next = din_bytes;
        end
        if (cmd.match_en)
        begin
            match_next = valid_reg && (key_reg == lookup_key);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        bytes_reg <= bytes_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign bytes = bytes_reg;
    assign match = match_reg;

endmodule

// ----- rtl/core/pablru_chain.sv -----
// Row of cells ordered by recency, with the registered hit encoder.
module pablru_chain
    import pablru_pkg::*;
#(
    parameter int ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  chain_cmd_t  cmd,
    input  logic [31:0] lookup_key,
    input  logic [63:0] head_bytes,
    output logic        hit_any,
    output logic [63:0] hit_bytes
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic [ENTRIES-1:0] cell_valid;
    logic [ENTRIES-1:0] cell_match;
    logic [31:0]        cell_key   [ENTRIES];
    logic [63:0]        cell_bytes [ENTRIES];

    logic               hit_any_reg;
    logic               hit_any_next;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [IDX_W-1:0]   hit_idx_next;
    logic [63:0]        hit_bytes_reg;
    logic [63:0]        hit_bytes_next;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            logic        din_valid;
            logic [31:0] din_key;
            logic [63:0] din_bytes;

            if (g == 0)
            begin : g_head
                assign din_valid = 1'b1;
                assign din_key   = lookup_key;
                assign din_bytes = head_bytes;
            end
            else
            begin : g_body
                assign din_valid = cell_valid[g-1];
                assign din_key   = cell_key[g-1];
                assign din_bytes = cell_bytes[g-1];
            end

            pablru_cell #(
                .IDX_W (IDX_W),
                .POS   (g)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .lookup_key (lookup_key),
                .hit_any    (hit_any_reg),
                .hit_idx    (hit_idx_reg),
                .din_valid  (din_valid),
                .din_key    (din_key),
                .din_bytes  (din_bytes),
                .valid      (cell_valid[g]),
                .key        (cell_key[g]),
                .bytes      (cell_bytes[g]),
                .match      (cell_match[g])
            );
        end
    endgenerate

    // keys are unique among valid cells, so at most one match bit is set
    always_comb
    begin
        hit_any_next   = hit_any_reg;
        hit_idx_next   = hit_idx_reg;
        hit_bytes_next = hit_bytes_reg;
        if (cmd.sel_en)
        begin
            hit_any_next   = |cell_match;
            hit_idx_next   = '0;
            hit_bytes_next = '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (cell_match[i])
                begin
                    hit_idx_next   = hit_idx_next | IDX_W'(i);
                    hit_bytes_next = hit_bytes_next | cell_bytes[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_any_reg <= 1'b0;
            hit_idx_reg <= '0;
        end
        else
        begin
            hit_any_reg <= hit_any_next;
            hit_idx_reg <= hit_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_bytes_reg <= hit_bytes_next;
    end

    assign hit_any   = hit_any_reg;
    assign hit_bytes = hit_bytes_reg;

endmodule

// ----- rtl/core/per_address_byte_counter_lru_unit.sv -----
// Top level: per-address byte counter over an exact LRU chain of cells.
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+---------------------------------
//  pkt     | pkt_valid | pkt_stall | pkt (pkt_t), frame header summary
//  res     | res_valid | res_stall | res (res_t), counted flag + totals
//
// A counted frame runs accept, then match / select / write through the cell
// chain for the source and again for the destination, then the result register
// load. A frame that is not counted goes from accept straight to the result load.
// Reset clears every valid bit in the chain at once; no clearing pass.
// pkt is taken only in idle; a stalled result holds the block in its last step.
module per_address_byte_counter_lru_unit
    import pablru_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic pkt_valid,
    output logic pkt_stall,
    input  pkt_t pkt,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    state_t      state_reg;
    state_t      state_next;
    pkt_t        item_reg;
    pkt_t        item_next;
    logic        phase_reg;
    logic        phase_next;
    logic        counted_reg;
    logic        counted_next;
    logic [63:0] src_total_reg;
    logic [63:0] src_total_next;
    logic [63:0] dst_total_reg;
    logic [63:0] dst_total_next;
    res_t        res_reg;
    res_t        res_next;
    logic        res_valid_reg;
    logic        res_valid_next;

    chain_cmd_t  cmd;
    logic        pkt_take;
    logic        pkt_ok;
    logic        res_free;
    logic [31:0] lookup_key;
    logic [63:0] amount;
    logic [63:0] sum;
    logic        hit_any;
    logic [63:0] hit_bytes;

    assign pkt_ok = (pkt.frame_length >= ETH_HDR_BYTES) && (pkt.ethertype == ETHERTYPE_IPV4)
                    && (pkt.frame_length >= ETH_IP_HDR_BYTES);
    assign res_free   = !res_valid_reg || !res_stall;
    assign lookup_key = phase_reg ? item_reg.dst_addr : item_reg.src_addr;
    assign amount     = {48'd0, item_reg.ip_total_length};
    assign sum        = hit_any ? (hit_bytes + amount) : amount;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pkt_valid)
                begin
                    state_next = pkt_ok ? ST_MATCH : ST_DONE;
                end
            end
            ST_MATCH: state_next = ST_SEL;
            ST_SEL:   state_next = ST_WRITE;
            ST_WRITE: state_next = phase_reg ? ST_DONE : ST_MATCH;
            ST_DONE:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pkt_stall      = 1'b1;
        pkt_take       = 1'b0;
        cmd            = '0;
        item_next      = item_reg;
        phase_next     = phase_reg;
        counted_next   = counted_reg;
        src_total_next = src_total_reg;
        dst_total_next = dst_total_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                pkt_stall = 1'b0;
                pkt_take  = pkt_valid;
                if (pkt_take)
                begin
                    item_next      = pkt;
                    phase_next     = 1'b0;
                    counted_next   = pkt_ok;
                    src_total_next = '0;
                    dst_total_next = '0;
                end
            end
            ST_MATCH: cmd.match_en = 1'b1;
            ST_SEL:   cmd.sel_en   = 1'b1;
            ST_WRITE:
            begin
                cmd.write_en = 1'b1;
                if (phase_reg)
                begin
                    dst_total_next = sum;
                end
                else
                begin
                    src_total_next = sum;
                    phase_next     = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (res_free)
                begin
                    res_next.counted   = counted_reg;
                    res_next.src_total = src_total_reg;
                    res_next.dst_total = dst_total_reg;
                    res_valid_next     = 1'b1;
                end
            end
            default:
            begin
                pkt_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        counted_reg   <= counted_next;
        src_total_reg <= src_total_next;
        dst_total_reg <= dst_total_next;
        res_reg       <= res_next;
    end

    pablru_chain #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .lookup_key (lookup_key),
        .head_bytes (sum),
        .hit_any    (hit_any),
        .hit_bytes  (hit_bytes)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
